/* src/sa_pkg.sv */
// Shared types, codes and constants for the shift array block.
`default_nettype none

package sa_pkg;

  // Field widths.
  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int LEN_W    = 5;
  localparam int MODE_W   = 3;
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;

  // Width used by a cell to compare its own index; covers up to 256 cells.
  localparam int CELL_IW  = 9;

  // Default store depth and reset value of the length register.
  localparam int                 MAX_ENTRIES_DEF = 16;
  localparam logic [LEN_W-1:0]   LEN_RESET       = 5'd16;

  // Register addresses.
  localparam logic [PADDR_W-1:0] ADDR_LEN = 2'd0;

  // Operation codes of an input beat.
  typedef enum logic [MODE_W-1:0] {
    MODE_READ   = 3'd0,
    MODE_WRITE  = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_FIND   = 3'd4
  } sa_mode_t;

  // Command broadcast to every cell.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_WRITE,
    CMD_INSERT,
    CMD_REMOVE
  } sa_cmd_t;

  // Search unit states.
  typedef enum logic {
    FS_IDLE,
    FS_SCAN
  } sa_fstate_t;

  // Control broadcast from the top level to the cell row.
  typedef struct packed {
    sa_cmd_t                   cmd;
    logic [POS_W-1:0]          pos;
    logic [LEN_W-1:0]          len;
    logic signed [DATA_W-1:0]  value;
  } sa_bcast_t;

  // Result handed back by the search unit.
  typedef struct packed {
    logic             done;
    logic             found;
    logic [POS_W-1:0] index;
  } sa_find_res_t;

endpackage

`default_nettype wire

/* src/sa_cell.sv */
// One storage cell of the shift array: holds a word, shifts with its neighbors, compares.
`default_nettype none

module sa_cell #(
  parameter int IDX = 0
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sa_pkg::sa_bcast_t                 bcast,
  input  wire logic signed [sa_pkg::DATA_W-1:0]  lower_i,
  input  wire logic signed [sa_pkg::DATA_W-1:0]  upper_i,
  output logic signed [sa_pkg::DATA_W-1:0]       data_o,
  output logic                                   match_o
);

  localparam logic [sa_pkg::CELL_IW-1:0] ID    = sa_pkg::CELL_IW'(IDX);
  localparam logic [sa_pkg::CELL_IW-1:0] ID_P1 = sa_pkg::CELL_IW'(IDX + 1);

  logic signed [sa_pkg::DATA_W-1:0] data_r;
  logic signed [sa_pkg::DATA_W-1:0] data_nxt;
  logic [sa_pkg::CELL_IW-1:0]       pos_x;
  logic [sa_pkg::CELL_IW-1:0]       len_x;

  assign pos_x = sa_pkg::CELL_IW'(bcast.pos);
  assign len_x = sa_pkg::CELL_IW'(bcast.len);

  // Decide whether this cell loads the new value, a neighbor's word, or holds.
  always_comb begin
    data_nxt = data_r;
    case (bcast.cmd)
      sa_pkg::CMD_WRITE: begin
        if (ID == pos_x) data_nxt = bcast.value;
      end
      sa_pkg::CMD_INSERT: begin
        if (ID == pos_x) begin
          data_nxt = bcast.value;
        end else if (ID > pos_x && ID < len_x) begin
          data_nxt = lower_i;
        end
      end
      sa_pkg::CMD_REMOVE: begin
        if (ID >= pos_x && ID_P1 < len_x) data_nxt = upper_i;
      end
      default: data_nxt = data_r;
    endcase
  end

  // Store is cleared to zero at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_o  = data_r;
  assign match_o = (data_r == bcast.value) && (ID < len_x);

endmodule

`default_nettype wire

/* src/sa_find.sv */
// Search unit: scans the registered match vector a group of bits per cycle.
`default_nettype none

module sa_find #(
  parameter int MAX_ENTRIES = sa_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [MAX_ENTRIES-1:0]       match_vec,
  input  wire logic [sa_pkg::LEN_W-1:0]     len,
  output logic                              busy,
  output sa_pkg::sa_find_res_t              res
);

  localparam int GROUP = (MAX_ENTRIES < 8) ? MAX_ENTRIES : 8;
  localparam int CW    = $clog2(MAX_ENTRIES + GROUP) + 1;
  localparam logic [CW-1:0] GROUP_C = CW'(GROUP);

  sa_pkg::sa_fstate_t           state_r;
  sa_pkg::sa_fstate_t           state_nxt;
  logic [MAX_ENTRIES-1:0]       match_r;
  logic [CW-1:0]                base_r;
  logic [sa_pkg::LEN_W-1:0]     len_r;
  logic [GROUP-1:0]             low_bits;
  logic                         hit;
  logic [CW-1:0]                pe;
  logic [CW-1:0]                hit_idx;
  logic                         end_scan;

  assign low_bits = match_r[GROUP-1:0];
  assign hit      = |low_bits;

  // Lowest set bit of the current group.
  always_comb begin
    pe = '0;
    for (int k = GROUP - 1; k >= 0; k--) begin
      if (low_bits[k]) pe = CW'(k);
    end
  end

  assign hit_idx  = base_r + pe;
  assign end_scan = hit || ((base_r + GROUP_C) >= CW'(len_r));

  // Next state and result.
  always_comb begin
    state_nxt = state_r;
    res.done  = 1'b0;
    res.found = 1'b0;
    res.index = '0;
    case (state_r)
      sa_pkg::FS_IDLE: begin
        if (start) state_nxt = sa_pkg::FS_SCAN;
      end
      sa_pkg::FS_SCAN: begin
        if (end_scan) begin
          state_nxt = sa_pkg::FS_IDLE;
          res.done  = 1'b1;
          res.found = hit;
          res.index = hit ? hit_idx[sa_pkg::POS_W-1:0] : '0;
        end
      end
      default: state_nxt = sa_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sa_pkg::FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Match vector shifts down one group per cycle while the base index advances.
  always_ff @(posedge clk) begin
    if (state_r == sa_pkg::FS_IDLE && start) begin
      match_r <= match_vec;
      base_r  <= '0;
      len_r   <= len;
    end else if (state_r == sa_pkg::FS_SCAN) begin
      match_r <= match_r >> GROUP;
      base_r  <= base_r + GROUP_C;
    end
  end

  assign busy = (state_r == sa_pkg::FS_SCAN);

endmodule

`default_nettype wire

/* src/shift_array_insert_remove_find.sv */
// Top level of the shift array: register port, cell row, search unit and result register.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | input     | in_valid / in_stall  | in_mode, in_position, in_value
//  out_    | output    | out_valid / out_stall| out_read_word, out_found_index,
//          |           |                      | out_found, out_error
//  cfg     | input     | psel/penable/pready  | paddr, pwdata, prdata (length_in_use)
//
// For read, write, insert and remove, every cell updates from its neighbor at
// the same edge at which the result register loads. Find is done by the search
// unit, which scans the registered match vector eight cells per cycle. Reset is
// synchronous and clears the store, the length register (to 16), the search
// unit state and the result valid flag. A result waiting under out_stall holds,
// and input is stalled until it leaves.
`default_nettype none

module shift_array_insert_remove_find #(
  parameter int MAX_ENTRIES = sa_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input channel.
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [sa_pkg::MODE_W-1:0]          in_mode,
  input  wire logic [sa_pkg::POS_W-1:0]           in_position,
  input  wire logic signed [sa_pkg::DATA_W-1:0]   in_value,
  // Result channel.
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [sa_pkg::DATA_W-1:0]        out_read_word,
  output logic [sa_pkg::POS_W-1:0]                out_found_index,
  output logic                                    out_found,
  output logic                                    out_error,
  // Configuration port.
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sa_pkg::PADDR_W-1:0]         paddr,
  input  wire logic [sa_pkg::PDATA_W-1:0]         pwdata,
  output logic [sa_pkg::PDATA_W-1:0]              prdata,
  output logic                                    pready
);

  localparam int RD_N = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;

  logic [sa_pkg::LEN_W-1:0]          len_r;
  logic [sa_pkg::LEN_W-1:0]          len_used;
  logic signed [sa_pkg::DATA_W-1:0]  cell_data [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]            match_vec;
  sa_pkg::sa_bcast_t                 bcast;
  sa_pkg::sa_find_res_t              fres;
  logic                              find_busy;
  logic                              in_acc;
  logic                              is_pos_op;
  logic                              pos_err;
  logic                              find_start;
  logic signed [sa_pkg::DATA_W-1:0]  rd_word;
  sa_pkg::sa_mode_t                  mode;

  logic                              out_valid_r;
  logic signed [sa_pkg::DATA_W-1:0]  read_word_r;
  logic [sa_pkg::POS_W-1:0]          found_index_r;
  logic                              found_r;
  logic                              error_r;

  // Configuration register; writes to other addresses are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= sa_pkg::LEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr == sa_pkg::ADDR_LEN) begin
      len_r <= pwdata[sa_pkg::LEN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == sa_pkg::ADDR_LEN) ? sa_pkg::PDATA_W'(len_r) : '0;

  // Length in use is limited to the store depth.
  assign len_used = (32'(len_r) > MAX_ENTRIES) ? sa_pkg::LEN_W'(MAX_ENTRIES) : len_r;

  // Input handshake and operation decode.
  assign in_stall   = find_busy || (out_valid_r && out_stall);
  assign in_acc     = in_valid && !in_stall;
  assign mode       = sa_pkg::sa_mode_t'(in_mode);
  assign is_pos_op  = (mode == sa_pkg::MODE_READ)   || (mode == sa_pkg::MODE_WRITE) ||
                      (mode == sa_pkg::MODE_INSERT) || (mode == sa_pkg::MODE_REMOVE);
  assign pos_err    = is_pos_op && (sa_pkg::LEN_W'(in_position) >= len_used);
  assign find_start = in_acc && (mode == sa_pkg::MODE_FIND);

  // Command broadcast to the cell row.
  always_comb begin
    bcast.cmd   = sa_pkg::CMD_HOLD;
    bcast.pos   = in_position;
    bcast.len   = len_used;
    bcast.value = in_value;
    if (in_acc && !pos_err) begin
      case (mode)
        sa_pkg::MODE_WRITE:  bcast.cmd = sa_pkg::CMD_WRITE;
        sa_pkg::MODE_INSERT: bcast.cmd = sa_pkg::CMD_INSERT;
        sa_pkg::MODE_REMOVE: bcast.cmd = sa_pkg::CMD_REMOVE;
        default:             bcast.cmd = sa_pkg::CMD_HOLD;
      endcase
    end
  end

  // Row of cells, each wired to both neighbors.
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic signed [sa_pkg::DATA_W-1:0] lower;
    logic signed [sa_pkg::DATA_W-1:0] upper;
    if (g == 0) begin : g_lo_edge
      assign lower = '0;
    end else begin : g_lo
      assign lower = cell_data[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_hi_edge
      assign upper = '0;
    end else begin : g_hi
      assign upper = cell_data[g+1];
    end
    sa_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bcast   (bcast),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[g]),
      .match_o (match_vec[g])
    );
  end

  // Read port over the cells a position can reach.
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (in_position == sa_pkg::POS_W'(k)) rd_word = cell_data[k];
    end
  end

  sa_find #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_find (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (find_start),
    .match_vec (match_vec),
    .len       (len_used),
    .busy      (find_busy),
    .res       (fres)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((in_acc && !find_start) || fres.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (fres.done) begin
      read_word_r   <= '0;
      found_index_r <= fres.index;
      found_r       <= fres.found;
      error_r       <= 1'b0;
    end else if (in_acc && !find_start) begin
      read_word_r   <= (mode == sa_pkg::MODE_READ && !pos_err) ? rd_word : '0;
      found_index_r <= '0;
      found_r       <= 1'b0;
      error_r       <= pos_err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_word   = read_word_r;
  assign out_found_index = found_index_r;
  assign out_found       = found_r;
  assign out_error       = error_r;

endmodule

`default_nettype wire

/* src/sa_checker.sv */
// Port-level checks for the shift array, bound to the top level.
`default_nettype none

module sa_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [sa_pkg::DATA_W-1:0]  out_read_word,
  input wire logic [sa_pkg::POS_W-1:0]          out_found_index,
  input wire logic                              out_found,
  input wire logic                              out_error
);

  // A result held under stall stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // An erroring beat carries no read word and no match.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_read_word == 0 && !out_found)
    else $error("error beat carries data");

  // A beat without a match reports index zero.
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_index == 0)
    else $error("index set without match");

  // A waiting result blocks new input beats.
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result waits");

endmodule

bind shift_array_insert_remove_find sa_checker u_sa_checker (.*);

`default_nettype wire
